// ----- src/iapm_pkg.sv -----
// ----------------------------------------------------------------------------
// iapm_pkg
// shared types, constants and saturation helpers of the inverter ac power core
// ----------------------------------------------------------------------------
package iapm_pkg;

    // register map, one 64-bit slot per register
    typedef enum logic [2:0] {
        REG_PACO = 3'd0,
        REG_PDCO = 3'd1,
        REG_VDCO = 3'd2,
        REG_PSO  = 3'd3,
        REG_C0   = 3'd4,
        REG_C1   = 3'd5,
        REG_C2   = 3'd6,
        REG_C3   = 3'd7
    } t_reg_idx;

    localparam int unsigned ADDR_W    = 6;
    localparam int unsigned DATA_W    = 64;

    // divider sizes
    localparam int unsigned DIV1_NUM_W = 53;
    localparam int unsigned DIV1_DEN_W = 29;
    localparam int unsigned DIV2_NUM_W = 40;
    localparam int unsigned DIV2_DEN_W = 24;

    // sidecar carried along the quotient divider
    typedef struct packed {
        logic signed [41:0] t2;
        logic               neg;
        logic               dzero;
        logic               num_pos;
        logic               num_neg;
        logic [23:0]        pdc;
        logic               idle;
    } t_div1_side;

    // sidecar carried along the efficiency divider
    typedef struct packed {
        logic [24:0] pac;
        logic [23:0] par;
        logic        zero;
    } t_eff_side;

    // voltage factor in q24, saturated to +-8.0
    function automatic logic signed [28:0] fac_sat(input logic signed [43:0] ph,
                                                   input logic signed [44:0] pl);
        logic signed [45:0] s;
        s = 46'(ph) + 46'($signed(pl[44:24])) + 46'sd16777216;
        if (s > 46'sd134217728) begin
            return 29'sd134217728;
        end else if (s < -46'sd134217728) begin
            return -29'sd134217728;
        end else begin
            return $signed(s[28:0]);
        end
    endfunction

    // floor of the curvature product over 2^44, saturated to +-2^40
    function automatic logic signed [41:0] t2_sat(input logic signed [110:0] p);
        logic signed [66:0] q;
        q = $signed(p[110:44]);
        if (q > 67'sd1099511627776) begin
            return 42'sd1099511627776;
        end else if (q < -67'sd1099511627776) begin
            return -42'sd1099511627776;
        end else begin
            return $signed(q[41:0]);
        end
    endfunction

endpackage

// ----- src/iapm_div_cell.sv -----
// ----------------------------------------------------------------------------
// iapm_div_cell
// one restoring division step: shifts in a dividend bit, emits a quotient bit
// ----------------------------------------------------------------------------
module iapm_div_cell #(
    parameter int unsigned NUM_W  = 53,
    parameter int unsigned DEN_W  = 29,
    parameter int unsigned SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [DEN_W-1:0]  i_rem,
    input  logic [NUM_W-1:0]  i_word,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [DEN_W-1:0]  o_rem,
    output logic [NUM_W-1:0]  o_word,
    output logic [DEN_W-1:0]  o_den,
    output logic [SIDE_W-1:0] o_side
);

    logic              r_valid;
    logic [DEN_W-1:0]  r_rem;
    logic [NUM_W-1:0]  r_word;
    logic [DEN_W-1:0]  r_den;
    logic [SIDE_W-1:0] r_side;

    logic [DEN_W:0]    w_trial;
    logic [DEN_W:0]    w_diff;
    logic              w_ge;

    assign w_trial = {i_rem, i_word[NUM_W-1]};
    assign w_ge    = w_trial >= {1'b0, i_den};
    assign w_diff  = w_trial - {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    // dividend bits leave at the top, quotient bits enter at the bottom
    always_ff @(posedge i_clk) begin
        r_rem  <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
        r_word <= {i_word[NUM_W-2:0], w_ge};
        r_den  <= i_den;
        r_side <= i_side;
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_word  = r_word;
    assign o_den   = r_den;
    assign o_side  = r_side;

endmodule

// ----- src/iapm_div.sv -----
// ----------------------------------------------------------------------------
// iapm_div
// unsigned divider built as a row of division cells, one quotient bit a cell
// ----------------------------------------------------------------------------
module iapm_div #(
    parameter int unsigned NUM_W  = 53,
    parameter int unsigned DEN_W  = 29,
    parameter int unsigned SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [NUM_W-1:0]  o_quo,
    output logic [SIDE_W-1:0] o_side
);

    logic              w_valid [0:NUM_W];
    logic [DEN_W-1:0]  w_rem   [0:NUM_W];
    logic [NUM_W-1:0]  w_word  [0:NUM_W];
    logic [DEN_W-1:0]  w_den   [0:NUM_W];
    logic [SIDE_W-1:0] w_side  [0:NUM_W];

    assign w_valid[0] = i_valid;
    assign w_rem[0]   = '0;
    assign w_word[0]  = i_num;
    assign w_den[0]   = i_den;
    assign w_side[0]  = i_side;

    for (genvar g = 0; g < NUM_W; g++) begin : g_cell
        iapm_div_cell #(
            .NUM_W  (NUM_W),
            .DEN_W  (DEN_W),
            .SIDE_W (SIDE_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .i_rem   (w_rem[g]),
            .i_word  (w_word[g]),
            .i_den   (w_den[g]),
            .i_side  (w_side[g]),
            .o_valid (w_valid[g+1]),
            .o_rem   (w_rem[g+1]),
            .o_word  (w_word[g+1]),
            .o_den   (w_den[g+1]),
            .o_side  (w_side[g+1])
        );
    end

    assign o_valid = w_valid[NUM_W];
    assign o_quo   = w_word[NUM_W];
    assign o_side  = w_side[NUM_W];

endmodule

// ----- src/inverter_ac_power_model_core.sv -----
// ----------------------------------------------------------------------------
// inverter_ac_power_model_core
// quadratic inverter ac power model, one operating point per clock
// ----------------------------------------------------------------------------
// channel   ports                                    handshake
// input     i_dc_power, i_dc_voltage                 i_start & !o_busy
// result    o_ac_power, o_parasitic_power,
//           o_part_load_ratio, o_efficiency          o_valid, one cycle
// config    psel penable pwrite paddr pwdata prdata  apb, pready tied high
//
// a new beat is taken every clock; o_busy stays low
// a result passes through ten arithmetic stages,
// a 53-cell quotient divider, one combine stage, a pair of 40-cell ratio
// dividers and the output register
// reset is synchronous; it empties the pipeline and restores the registers
// results cannot be held off, so nothing in the pipe ever stalls
// ----------------------------------------------------------------------------
module inverter_ac_power_model_core #(
    parameter int NIGHT_TARE_POWER = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    output logic                         o_busy,
    input  logic [23:0]                  i_dc_power,
    input  logic [18:0]                  i_dc_voltage,
    output logic                         o_valid,
    output logic signed [24:0]           o_ac_power,
    output logic [23:0]                  o_parasitic_power,
    output logic [17:0]                  o_part_load_ratio,
    output logic [16:0]                  o_efficiency,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [iapm_pkg::ADDR_W-1:0]  paddr,
    input  logic [iapm_pkg::DATA_W-1:0]  pwdata,
    output logic [iapm_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);

    localparam logic [23:0] NT     = NIGHT_TARE_POWER[23:0];
    localparam logic [24:0] NEG_NT = 25'd0 - {1'b0, NT};
    localparam int unsigned LAT    = 10 + iapm_pkg::DIV1_NUM_W + 1
                                     + iapm_pkg::DIV2_NUM_W + 1;

    // ---------------- configuration ----------------
    logic [23:0] r_paco, r_pdco, r_pso;
    logic [18:0] r_vdco;
    logic [47:0] r_c0, r_c1, r_c2, r_c3;
    logic        w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_paco <= '0;
            r_pdco <= 24'd1;
            r_vdco <= '0;
            r_pso  <= '0;
            r_c0   <= '0;
            r_c1   <= '0;
            r_c2   <= '0;
            r_c3   <= '0;
        end else if (w_cfg_wr) begin
            case (iapm_pkg::t_reg_idx'(paddr[5:3]))
                iapm_pkg::REG_PACO: r_paco <= pwdata[23:0];
                iapm_pkg::REG_PDCO: r_pdco <= pwdata[23:0];
                iapm_pkg::REG_VDCO: r_vdco <= pwdata[18:0];
                iapm_pkg::REG_PSO:  r_pso  <= pwdata[23:0];
                iapm_pkg::REG_C0:   r_c0   <= pwdata[47:0];
                iapm_pkg::REG_C1:   r_c1   <= pwdata[47:0];
                iapm_pkg::REG_C2:   r_c2   <= pwdata[47:0];
                iapm_pkg::REG_C3:   r_c3   <= pwdata[47:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (iapm_pkg::t_reg_idx'(paddr[5:3]))
            iapm_pkg::REG_PACO: prdata = {40'd0, r_paco};
            iapm_pkg::REG_PDCO: prdata = {40'd0, r_pdco};
            iapm_pkg::REG_VDCO: prdata = {45'd0, r_vdco};
            iapm_pkg::REG_PSO:  prdata = {40'd0, r_pso};
            iapm_pkg::REG_C0:   prdata = {16'd0, r_c0};
            iapm_pkg::REG_C1:   prdata = {16'd0, r_c1};
            iapm_pkg::REG_C2:   prdata = {16'd0, r_c2};
            iapm_pkg::REG_C3:   prdata = {16'd0, r_c3};
            default:            prdata = '0;
        endcase
    end

    // ---------------- input beat ----------------
    logic w_acc;
    assign o_busy = 1'b0;
    assign w_acc  = i_start & ~o_busy;

    // stage valids
    logic [10:1] r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[9:1], w_acc};
        end
    end

    // stage 1: voltage offset, idle test
    logic        [23:0] r1_pdc;
    logic signed [19:0] r1_dv;
    logic               r1_idle;

    always_ff @(posedge i_clk) begin
        r1_pdc  <= i_dc_power;
        r1_dv   <= $signed({1'b0, i_dc_voltage}) - $signed({1'b0, r_vdco});
        r1_idle <= i_dc_power <= r_pso;
    end

    // stage 2: coefficient times offset, split in 24-bit halves
    logic signed [43:0] r2_ph_a, r2_ph_b, r2_ph_c;
    logic signed [44:0] r2_pl_a, r2_pl_b, r2_pl_c;
    logic        [23:0] r2_pdc;
    logic               r2_idle;

    always_ff @(posedge i_clk) begin
        r2_ph_a <= 44'($signed(r_c1[47:24])) * 44'(r1_dv);
        r2_ph_b <= 44'($signed(r_c2[47:24])) * 44'(r1_dv);
        r2_ph_c <= 44'($signed(r_c3[47:24])) * 44'(r1_dv);
        r2_pl_a <= 45'($signed({1'b0, r_c1[23:0]})) * 45'(r1_dv);
        r2_pl_b <= 45'($signed({1'b0, r_c2[23:0]})) * 45'(r1_dv);
        r2_pl_c <= 45'($signed({1'b0, r_c3[23:0]})) * 45'(r1_dv);
        r2_pdc  <= r1_pdc;
        r2_idle <= r1_idle;
    end

    // stage 3: q24 factors
    logic signed [28:0] r3_fa, r3_fb, r3_fc;
    logic        [23:0] r3_pdc;
    logic               r3_idle;

    always_ff @(posedge i_clk) begin
        r3_fa   <= iapm_pkg::fac_sat(r2_ph_a, r2_pl_a);
        r3_fb   <= iapm_pkg::fac_sat(r2_ph_b, r2_pl_b);
        r3_fc   <= iapm_pkg::fac_sat(r2_ph_c, r2_pl_c);
        r3_pdc  <= r2_pdc;
        r3_idle <= r2_idle;
    end

    // stage 4: adjusted a, b and curvature partials
    logic signed [53:0] w_pa, w_pb;
    logic signed [28:0] r4_a, r4_b;
    logic signed [52:0] r4_chh;
    logic signed [53:0] r4_chl;
    logic        [23:0] r4_pdc;
    logic               r4_idle;

    assign w_pa = 54'($signed({1'b0, r_pdco})) * 54'(r3_fa);
    assign w_pb = 54'($signed({1'b0, r_pso})) * 54'(r3_fb);

    always_ff @(posedge i_clk) begin
        r4_a    <= $signed(w_pa[52:24]);
        r4_b    <= $signed(w_pb[52:24]);
        r4_chh  <= 53'($signed(r_c0[47:24])) * 53'(r3_fc);
        r4_chl  <= 54'($signed({1'b0, r_c0[23:0]})) * 54'(r3_fc);
        r4_pdc  <= r3_pdc;
        r4_idle <= r3_idle;
    end

    // stage 5: curvature, differences
    logic signed [52:0] r5_c;
    logic signed [29:0] r5_d, r5_e, r5_f;
    logic        [23:0] r5_pdc;
    logic               r5_idle;

    always_ff @(posedge i_clk) begin
        r5_c    <= r4_chh + 53'($signed(r4_chl[53:24]));
        r5_d    <= 30'(r4_a) - 30'(r4_b);
        r5_e    <= 30'($signed({1'b0, r4_pdc})) - 30'(r4_b);
        r5_f    <= 30'($signed({1'b0, r4_pdc})) - 30'(r4_a);
        r5_pdc  <= r4_pdc;
        r5_idle <= r4_idle;
    end

    // stage 6: numerator and (pdc-b)(pdc-a)
    logic signed [54:0] r6_num;
    logic signed [57:0] r6_ef;
    logic signed [52:0] r6_c;
    logic signed [29:0] r6_d;
    logic        [23:0] r6_pdc;
    logic               r6_idle;

    always_ff @(posedge i_clk) begin
        r6_num  <= 55'($signed({1'b0, r_paco})) * 55'(r5_e);
        r6_ef   <= 58'(r5_e) * 58'(r5_f);
        r6_c    <= r5_c;
        r6_d    <= r5_d;
        r6_pdc  <= r5_pdc;
        r6_idle <= r5_idle;
    end

    // stage 7: curvature product in four partials
    logic signed [29:0] w_ef_hi;
    logic        [27:0] w_ef_lo;
    logic signed [26:0] w_c_hi;
    logic        [25:0] w_c_lo;
    logic signed [56:0] r7_hh, r7_lh;
    logic signed [55:0] r7_hl;
    logic        [53:0] r7_ll;
    logic signed [54:0] r7_num;
    logic signed [29:0] r7_d;
    logic        [23:0] r7_pdc;
    logic               r7_idle;

    assign w_ef_hi = $signed(r6_ef[57:28]);
    assign w_ef_lo = r6_ef[27:0];
    assign w_c_hi  = $signed(r6_c[52:26]);
    assign w_c_lo  = r6_c[25:0];

    always_ff @(posedge i_clk) begin
        r7_hh   <= 57'(w_c_hi) * 57'(w_ef_hi);
        r7_hl   <= 56'(w_c_hi) * 56'($signed({1'b0, w_ef_lo}));
        r7_lh   <= 57'($signed({1'b0, w_c_lo})) * 57'(w_ef_hi);
        r7_ll   <= 54'(w_c_lo) * 54'(w_ef_lo);
        r7_num  <= r6_num;
        r7_d    <= r6_d;
        r7_pdc  <= r6_pdc;
        r7_idle <= r6_idle;
    end

    // stage 8: middle and low partials summed
    logic signed [86:0] r8_mid;
    logic signed [56:0] r8_hh;
    logic signed [54:0] r8_num;
    logic signed [29:0] r8_d;
    logic        [23:0] r8_pdc;
    logic               r8_idle;

    always_ff @(posedge i_clk) begin
        r8_mid  <= (87'(r7_hl) <<< 26) + (87'(r7_lh) <<< 28)
                   + 87'($signed({1'b0, r7_ll}));
        r8_hh   <= r7_hh;
        r8_num  <= r7_num;
        r8_d    <= r7_d;
        r8_pdc  <= r7_pdc;
        r8_idle <= r7_idle;
    end

    // stage 9: full product
    logic signed [110:0] r9_p;
    logic signed [54:0]  r9_num;
    logic signed [29:0]  r9_d;
    logic        [23:0]  r9_pdc;
    logic                r9_idle;

    always_ff @(posedge i_clk) begin
        r9_p    <= (111'(r8_hh) <<< 54) + 111'(r8_mid);
        r9_num  <= r8_num;
        r9_d    <= r8_d;
        r9_pdc  <= r8_pdc;
        r9_idle <= r8_idle;
    end

    // stage 10: quadratic term
    logic signed [41:0] r10_t2;
    logic signed [54:0] r10_num;
    logic signed [29:0] r10_d;
    logic        [23:0] r10_pdc;
    logic               r10_idle;

    always_ff @(posedge i_clk) begin
        r10_t2   <= iapm_pkg::t2_sat(r9_p);
        r10_num  <= r9_num;
        r10_d    <= r9_d;
        r10_pdc  <= r9_pdc;
        r10_idle <= r9_idle;
    end

    // ---------------- quotient divider ----------------
    logic [54:0]                       w_num_abs;
    logic [29:0]                       w_d_abs;
    iapm_pkg::t_div1_side              w_s1_in, w_s1_out;
    logic                              w_d1_vld;
    logic [iapm_pkg::DIV1_NUM_W-1:0]   w_d1_quo;
    logic [$bits(iapm_pkg::t_div1_side)-1:0] w_s1_bits;

    assign w_num_abs = r10_num[54] ? 55'd0 - r10_num : r10_num;
    assign w_d_abs   = r10_d[29] ? 30'd0 - r10_d : r10_d;

    always_comb begin
        w_s1_in.t2      = r10_t2;
        w_s1_in.neg     = r10_num[54] ^ r10_d[29];
        w_s1_in.dzero   = r10_d == '0;
        w_s1_in.num_pos = ~r10_num[54] && (r10_num != '0);
        w_s1_in.num_neg = r10_num[54];
        w_s1_in.pdc     = r10_pdc;
        w_s1_in.idle    = r10_idle;
    end

    iapm_div #(
        .NUM_W  (iapm_pkg::DIV1_NUM_W),
        .DEN_W  (iapm_pkg::DIV1_DEN_W),
        .SIDE_W ($bits(iapm_pkg::t_div1_side))
    ) u_div_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v[10]),
        .i_num   (w_num_abs[iapm_pkg::DIV1_NUM_W-1:0]),
        .i_den   (w_d_abs[iapm_pkg::DIV1_DEN_W-1:0]),
        .i_side  (w_s1_in),
        .o_valid (w_d1_vld),
        .o_quo   (w_d1_quo),
        .o_side  (w_s1_bits)
    );

    assign w_s1_out = iapm_pkg::t_div1_side'(w_s1_bits);

    // stage 11: ac power, idle override and clamps
    logic signed [54:0] w_term1;
    logic signed [55:0] w_sum;
    logic signed [55:0] w_pac;
    logic               r11_v;
    logic        [24:0] r11_pac;
    logic        [23:0] r11_par;
    logic        [23:0] r11_pdc;

    always_comb begin
        if (w_s1_out.dzero) begin
            if (w_s1_out.num_pos) begin
                w_term1 = 55'sd1099511627776;
            end else if (w_s1_out.num_neg) begin
                w_term1 = -55'sd1099511627776;
            end else begin
                w_term1 = '0;
            end
        end else if (w_s1_out.neg) begin
            w_term1 = 55'sd0 - $signed({2'b0, w_d1_quo});
        end else begin
            w_term1 = $signed({2'b0, w_d1_quo});
        end
        w_sum = 56'(w_term1) + 56'(w_s1_out.t2);
        if (w_s1_out.idle) begin
            w_pac = 56'($signed(NEG_NT));
        end else begin
            w_pac = w_sum;
        end
        if (w_pac > $signed({32'd0, r_paco})) begin
            w_pac = $signed({32'd0, r_paco});
        end else if (w_pac < -56'sd16777216) begin
            w_pac = -56'sd16777216;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r11_v <= 1'b0;
        end else begin
            r11_v <= w_d1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r11_pac <= w_pac[24:0];
        r11_par <= w_s1_out.idle ? NT : 24'd0;
        r11_pdc <= w_s1_out.pdc;
    end

    // ---------------- ratio dividers ----------------
    logic                              w_pac_pos;
    iapm_pkg::t_eff_side               w_se_in, w_se_out;
    logic [$bits(iapm_pkg::t_eff_side)-1:0] w_se_bits;
    logic                              w_eff_vld, w_plr_vld;
    logic [iapm_pkg::DIV2_NUM_W-1:0]   w_eff_quo, w_plr_quo;
    logic                              w_plr_zero;

    assign w_pac_pos = ~r11_pac[24] && (r11_pac != '0);

    always_comb begin
        w_se_in.pac  = r11_pac;
        w_se_in.par  = r11_par;
        w_se_in.zero = (r11_pdc == '0) || !w_pac_pos;
    end

    iapm_div #(
        .NUM_W  (iapm_pkg::DIV2_NUM_W),
        .DEN_W  (iapm_pkg::DIV2_DEN_W),
        .SIDE_W ($bits(iapm_pkg::t_eff_side))
    ) u_div_eff (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r11_v),
        .i_num   (w_pac_pos ? {r11_pac[23:0], 16'd0} : 40'd0),
        .i_den   (r11_pdc),
        .i_side  (w_se_in),
        .o_valid (w_eff_vld),
        .o_quo   (w_eff_quo),
        .o_side  (w_se_bits)
    );

    assign w_se_out = iapm_pkg::t_eff_side'(w_se_bits);

    // zero dc power gives a zero ratio whatever the rated power
    iapm_div #(
        .NUM_W  (iapm_pkg::DIV2_NUM_W),
        .DEN_W  (iapm_pkg::DIV2_DEN_W),
        .SIDE_W (1)
    ) u_div_plr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r11_v),
        .i_num   ({r11_pdc, 16'd0}),
        .i_den   (r_pdco),
        .i_side  (r11_pdc == '0),
        .o_valid (w_plr_vld),
        .o_quo   (w_plr_quo),
        .o_side  (w_plr_zero)
    );

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= w_eff_vld & w_plr_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        o_ac_power        <= $signed(w_se_out.pac);
        o_parasitic_power <= w_se_out.par;
        if (w_se_out.zero) begin
            o_efficiency <= '0;
        end else if (w_eff_quo > 40'd65536) begin
            o_efficiency <= 17'd65536;
        end else begin
            o_efficiency <= w_eff_quo[16:0];
        end
        if (w_plr_zero) begin
            o_part_load_ratio <= '0;
        end else if (w_plr_quo > 40'd131072) begin
            o_part_load_ratio <= 18'd131072;
        end else begin
            o_part_load_ratio <= w_plr_quo[17:0];
        end
    end

    // ---------------- checks ----------------
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |-> ##LAT o_valid)
        else $error("result beat missing after fixed latency");

    a_div_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_eff_vld == w_plr_vld)
        else $error("ratio dividers out of step");

    a_ratio_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_efficiency <= 17'd65536) && (o_part_load_ratio <= 18'd131072))
        else $error("ratio out of range");

    a_tare: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_parasitic_power != '0)) |-> (o_ac_power == $signed(NEG_NT)))
        else $error("tare drawn while inverting");

endmodule
